### design/triangle_plane_clipper_unit_macros.svh
// Assertion macros shared by the triangle clipper checker.
// No dependencies; included by the checker file only.
`ifndef TRIANGLE_PLANE_CLIPPER_UNIT_MACROS_SVH
`define TRIANGLE_PLANE_CLIPPER_UNIT_MACROS_SVH
// next-cycle implication, masked while reset is high
`define TPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("triangle clipper check failed");
// next-cycle implication, checked through reset as well
`define TPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("triangle clipper check failed");
`endif

### design/tpc_pkg.sv
// Shared widths, types and codes of the triangle plane clipper.
// No dependencies; imported by every module of the block.
package tpc_pkg;

   localparam int COORD_W    = 32;
   localparam int COLOR_W    = 24;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = DIFF_W + COORD_W;
   localparam int DIST_W     = PROD_W + 2;
   localparam int DEN_W      = DIST_W + 1;
   localparam int MAG_W      = COORD_W;
   localparam int QUO_W      = COORD_W;
   localparam int NUM_W      = DEN_W + QUO_W;
   localparam int CHUNK_W    = 23;
   localparam int CHUNK_N    = 3;
   localparam int PP_W       = CHUNK_W + MAG_W;
   localparam int DIST_LAT   = 3;
   localparam int LANE_LAT   = 3 + QUO_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // config register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_Z  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 3'd5;

   localparam logic signed [COORD_W-1:0] POINT_Z_RST  = 32'sd6554;
   localparam logic signed [COORD_W-1:0] NORMAL_Z_RST = 32'sd65536;

   // x sits in the low bits
   typedef struct packed {
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } vert_type;

   // vertex 0 in the low bits, color on top
   typedef struct packed {
      logic [COLOR_W-1:0] color;
      vert_type           v2;
      vert_type           v1;
      vert_type           v0;
   } tri_type;

   localparam int TRI_W = $bits(tri_type);

   typedef enum logic [1:0] {
      CASE_NONE,
      CASE_ALL,
      CASE_ONE,
      CASE_TWO
   } case_type;

   // what reaches the output stage for one input triangle
   typedef struct packed {
      case_type           ncase;
      vert_type           sv0;
      vert_type           sv1;
      vert_type           sv2;
      vert_type           x0;
      vert_type           x1;
      logic [COLOR_W-1:0] color;
   } mrg_item_type;

endpackage

### design/tpc_dist_lane.sv
// Signed plane distance of one vertex, n.(v - p), in three stages.
// Depends on tpc_pkg.
module tpc_dist_lane import tpc_pkg::*; (
   input  logic                     clock,
   input  logic                     advance,
   input  vert_type                 vert,
   input  vert_type                 point,
   input  vert_type                 normal,
   output logic signed [DIST_W-1:0] distance
);

   logic signed [DIFF_W-1:0] dx_in, dy_in, dz_in, dx_ff, dy_ff, dz_ff;
   logic signed [PROD_W-1:0] px_in, py_in, pz_in, px_ff, py_ff, pz_ff;
   logic signed [DIST_W-1:0] dist_in, dist_ff;

   // vertex minus plane point, exact
   always_comb begin
      dx_in = $signed({vert.x[COORD_W-1], vert.x}) - $signed({point.x[COORD_W-1], point.x});
      dy_in = $signed({vert.y[COORD_W-1], vert.y}) - $signed({point.y[COORD_W-1], point.y});
      dz_in = $signed({vert.z[COORD_W-1], vert.z}) - $signed({point.z[COORD_W-1], point.z});
   end

   // one product per axis
   always_comb begin
      px_in = dx_ff * normal.x;
      py_in = dy_ff * normal.y;
      pz_in = dz_ff * normal.z;
   end

   always_comb begin
      dist_in = px_ff + py_ff + pz_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dz_ff   <= dz_in;
         px_ff   <= px_in;
         py_ff   <= py_in;
         pz_ff   <= pz_in;
         dist_ff <= dist_in;
      end
   end

   assign distance = dist_ff;

endmodule

### design/tpc_isect_lane.sv
// One coordinate of an edge/plane crossing: a + trunc(da*(b-a)/(da-db)).
// Split multiply, then a restoring divider one quotient bit per stage. Uses tpc_pkg.
module tpc_isect_lane import tpc_pkg::*; (
   input  logic                      clock,
   input  logic                      advance,
   input  logic signed [COORD_W-1:0] a_coord,
   input  logic signed [COORD_W-1:0] b_coord,
   input  logic signed [DIST_W-1:0]  a_dist,
   input  logic signed [DIST_W-1:0]  b_dist,
   output logic signed [COORD_W-1:0] coord
);

   localparam int CHUNK_PAD = CHUNK_N * CHUNK_W - DIST_W;

   // stage 1: difference, magnitude, denominator
   logic signed [DIFF_W-1:0]  diff, ndiff;
   logic                      neg_in;
   logic [MAG_W-1:0]          mag_in;
   logic signed [DEN_W-1:0]   den_in;
   logic signed [COORD_W-1:0] a1_ff;
   logic                      neg1_ff;
   logic [MAG_W-1:0]          mag1_ff;
   logic [DEN_W-1:0]          den1_ff;
   logic [DIST_W-1:0]         dam1_ff;

   // stage 2: partial products
   logic [CHUNK_N*CHUNK_W-1:0] dpad;
   logic [PP_W-1:0]            pp_in [CHUNK_N];
   logic [PP_W-1:0]            pp_ff [CHUNK_N];
   logic signed [COORD_W-1:0]  a2_ff;
   logic                       neg2_ff;
   logic [DEN_W-1:0]           den2_ff;

   // stage 3 and divider stages
   logic [NUM_W-1:0]          num_in;
   logic [NUM_W-1:0]          rem_ff [0:QUO_W];
   logic [NUM_W-1:0]          rem_in [0:QUO_W];
   logic [QUO_W-1:0]          quo_ff [0:QUO_W];
   logic [QUO_W-1:0]          quo_in [0:QUO_W];
   logic [DEN_W-1:0]          den_ff [0:QUO_W];
   logic signed [COORD_W-1:0] a_ff   [0:QUO_W];
   logic                      neg_ff [0:QUO_W];

   // final correction
   logic signed [COORD_W+1:0] qext, sum;
   logic signed [COORD_W-1:0] coord_in, coord_ff;

   always_comb begin
      diff   = $signed({b_coord[COORD_W-1], b_coord}) - $signed({a_coord[COORD_W-1], a_coord});
      ndiff  = -diff;
      neg_in = diff[DIFF_W-1];
      mag_in = neg_in ? ndiff[MAG_W-1:0] : diff[MAG_W-1:0];
      den_in = $signed({a_dist[DIST_W-1], a_dist}) - $signed({b_dist[DIST_W-1], b_dist});
   end

   // distance cut into chunks so each multiply stays narrow
   always_comb begin
      dpad = {{CHUNK_PAD{1'b0}}, dam1_ff};
      for (int c = 0; c < CHUNK_N; c++) begin
         pp_in[c] = dpad[c*CHUNK_W +: CHUNK_W] * mag1_ff;
      end
   end

   always_comb begin
      num_in = '0;
      for (int c = 0; c < CHUNK_N; c++) begin
         num_in = num_in + (NUM_W'(pp_ff[c]) << (c * CHUNK_W));
      end
   end

   // restoring divide, quotient MSB first
   always_comb begin
      logic [NUM_W-1:0] trial;
      rem_in[0] = num_in;
      quo_in[0] = '0;
      for (int j = 0; j < QUO_W; j++) begin
         trial = NUM_W'(den_ff[j]) << (QUO_W - 1 - j);
         if (rem_ff[j] >= trial) begin
            rem_in[j+1] = rem_ff[j] - trial;
            quo_in[j+1] = quo_ff[j] | (QUO_W'(1) << (QUO_W - 1 - j));
         end else begin
            rem_in[j+1] = rem_ff[j];
            quo_in[j+1] = quo_ff[j];
         end
      end
   end

   // apply sign and offset by the inside endpoint
   always_comb begin
      qext     = $signed({2'b00, quo_ff[QUO_W]});
      sum      = $signed({{2{a_ff[QUO_W][COORD_W-1]}}, a_ff[QUO_W]})
                 + (neg_ff[QUO_W] ? -qext : qext);
      coord_in = sum[COORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff   <= a_coord;
         neg1_ff <= neg_in;
         mag1_ff <= mag_in;
         den1_ff <= den_in;
         dam1_ff <= a_dist;
         for (int c = 0; c < CHUNK_N; c++) begin
            pp_ff[c] <= pp_in[c];
         end
         a2_ff     <= a1_ff;
         neg2_ff   <= neg1_ff;
         den2_ff   <= den1_ff;
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         den_ff[0] <= den2_ff;
         a_ff[0]   <= a2_ff;
         neg_ff[0] <= neg2_ff;
         for (int j = 0; j < QUO_W; j++) begin
            rem_ff[j+1] <= rem_in[j+1];
            quo_ff[j+1] <= quo_in[j+1];
            den_ff[j+1] <= den_ff[j];
            a_ff[j+1]   <= a_ff[j];
            neg_ff[j+1] <= neg_ff[j];
         end
         coord_ff <= coord_in;
      end
   end

   assign coord = coord_ff;

endmodule

### design/tpc_out_merge.sv
// Output stage: turns one clipped item into zero, one or two triangles.
// Holds up to two triangles; depends on tpc_pkg.
module tpc_out_merge import tpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  mrg_item_type     item,
   output logic             advance,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [TRI_W-1:0] rsp_tdata,
   output logic             rsp_tlast
);

   logic [1:0] cnt_ff, cnt_in, new_cnt;
   tri_type    head_ff, head_in, next_ff, next_in, t0, t1;
   logic       head_last_ff, head_last_in, t0_last;
   logic       take, can_load, load;

   // build the triangles of the incoming item
   always_comb begin
      t0       = '{color: item.color, v0: item.sv0, v1: item.sv1, v2: item.sv2};
      t1       = '{color: item.color, v0: item.sv1, v1: item.x0, v2: item.x1};
      t0_last  = 1'b1;
      new_cnt  = 2'd1;
      unique case (item.ncase)
         CASE_NONE: new_cnt = 2'd0;
         CASE_ALL:  new_cnt = 2'd1;
         CASE_ONE: begin
            t0.v1 = item.x0;
            t0.v2 = item.x1;
         end
         CASE_TWO: begin
            t0.v2   = item.x0;
            t0_last = 1'b0;
            new_cnt = 2'd2;
         end
      endcase
   end

   always_comb begin
      take     = (cnt_ff != 2'd0) && rsp_tready;
      can_load = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && take);
      load     = item_valid && can_load;
      advance  = !item_valid || can_load;
   end

   // buffer update
   always_comb begin
      cnt_in       = cnt_ff;
      head_in      = head_ff;
      head_last_in = head_last_ff;
      next_in      = next_ff;
      if (load) begin
         cnt_in       = new_cnt;
         head_in      = t0;
         head_last_in = t0_last;
         next_in      = t1;
      end else if (take) begin
         cnt_in       = cnt_ff - 2'd1;
         head_in      = next_ff;
         head_last_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff      <= head_in;
      head_last_ff <= head_last_in;
      next_ff      <= next_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = head_ff;
   assign rsp_tlast  = head_last_ff;

endmodule

### design/triangle_plane_clipper_unit.sv
// Triangle plane clipper: clips one triangle per transaction against a plane.
// Depends on tpc_pkg, tpc_dist_lane, tpc_isect_lane and tpc_out_merge.
//
// Input channel req_*: one triangle per transaction (three Q16.16 vertices and
// a 24-bit color). Output channel rsp_*: zero, one or two triangles per input,
// tlast marks the final triangle of one input. The csr_* port writes the plane
// point and inward normal; write it only while the block is empty.
// The path from acceptance to the first result triangle runs through the input
// register, the 3-stage distance lanes, a select stage, the 36-stage crossing
// lanes (32 of them the one-bit-per-stage divider) and the output buffer.
// The block takes a new triangle every cycle while each input makes at most one
// result and the receiver is ready; an input that splits into two triangles
// stalls the pipeline while both of its triangles wait in the output buffer.
// Six crossing lanes (two crossings times three axes) run side by side and
// the output stage merges their coordinates into the emitted triangles.
// Reset (synchronous) empties the pipeline and restores the default plane.
// A stalled receiver stops the whole pipeline once a valid item meets a nonempty
// output buffer; the held triangle stays on rsp_tdata until it is taken.
module triangle_plane_clipper_unit import tpc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // configuration write port
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // input triangles
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // in_x0, in_y0, in_z0, in_x1, in_y1, in_z1, in_x2, in_y2, in_z2, in_color
   input  logic [TRI_W-1:0]      req_tdata,
   // result triangles
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_x0, out_y0, out_z0, out_x1, out_y1, out_z1, out_x2, out_y2, out_z2, out_color
   output logic [TRI_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast    // last_of_run
);

   typedef struct packed {
      case_type           ncase;
      vert_type           sv0;
      vert_type           sv1;
      vert_type           sv2;
      logic [COLOR_W-1:0] color;
   } hold_type;

   logic     advance;
   vert_type pt_ff, pt_in, nrm_ff, nrm_in;

   logic     in_valid_ff;
   tri_type  in_tri_ff;
   logic     dval_ff [1:DIST_LAT];
   tri_type  dtri_ff [1:DIST_LAT];
   logic signed [DIST_W-1:0] d0, d1, d2;

   logic [2:0]          in_mask;
   logic [1:0]          i_sv0, i_sv1, i_a0, i_b0, i_a1, i_b1;
   case_type            case_in;
   logic                sel_valid_ff;
   hold_type            sel_hold_ff, sel_hold_in;
   vert_type            sel_a_ff [2];
   vert_type            sel_b_ff [2];
   vert_type            sel_a_in [2];
   vert_type            sel_b_in [2];
   logic signed [DIST_W-1:0] sel_da_ff [2];
   logic signed [DIST_W-1:0] sel_db_ff [2];
   logic signed [DIST_W-1:0] sel_da_in [2];
   logic signed [DIST_W-1:0] sel_db_in [2];

   logic         lval_ff  [1:LANE_LAT];
   hold_type     lhold_ff [1:LANE_LAT];
   vert_type     xs [2];
   mrg_item_type item;

   function automatic vert_type pick_vert(input logic [1:0] idx, input vert_type v0,
                                          input vert_type v1, input vert_type v2);
      unique case (idx)
         2'd0:    pick_vert = v0;
         2'd1:    pick_vert = v1;
         default: pick_vert = v2;
      endcase
   endfunction

   function automatic logic signed [DIST_W-1:0] pick_dist(input logic [1:0] idx,
      input logic signed [DIST_W-1:0] e0, input logic signed [DIST_W-1:0] e1,
      input logic signed [DIST_W-1:0] e2);
      unique case (idx)
         2'd0:    pick_dist = e0;
         2'd1:    pick_dist = e1;
         default: pick_dist = e2;
      endcase
   endfunction

   // configuration registers
   always_comb begin
      pt_in  = pt_ff;
      nrm_in = nrm_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_POINT_X:  pt_in.x  = $signed(csr_wdata);
            CSR_POINT_Y:  pt_in.y  = $signed(csr_wdata);
            CSR_POINT_Z:  pt_in.z  = $signed(csr_wdata);
            CSR_NORMAL_X: nrm_in.x = $signed(csr_wdata);
            CSR_NORMAL_Y: nrm_in.y = $signed(csr_wdata);
            CSR_NORMAL_Z: nrm_in.z = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff  <= '{x: '0, y: '0, z: POINT_Z_RST};
         nrm_ff <= '{x: '0, y: '0, z: NORMAL_Z_RST};
      end else begin
         pt_ff  <= pt_in;
         nrm_ff <= nrm_in;
      end
   end

   // no transaction is taken while reset is high
   assign req_tready = advance && !reset;

   // input register and distance-aligned delay
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         for (int k = 1; k <= DIST_LAT; k++) dval_ff[k] <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_tvalid;
         dval_ff[1]  <= in_valid_ff;
         for (int k = 2; k <= DIST_LAT; k++) dval_ff[k] <= dval_ff[k-1];
      end
      if (advance) begin
         in_tri_ff  <= tri_type'(req_tdata);
         dtri_ff[1] <= in_tri_ff;
         for (int k = 2; k <= DIST_LAT; k++) dtri_ff[k] <= dtri_ff[k-1];
      end
   end

   tpc_dist_lane u_dist0 (.clock(clock), .advance(advance), .vert(in_tri_ff.v0),
                          .point(pt_ff), .normal(nrm_ff), .distance(d0));
   tpc_dist_lane u_dist1 (.clock(clock), .advance(advance), .vert(in_tri_ff.v1),
                          .point(pt_ff), .normal(nrm_ff), .distance(d1));
   tpc_dist_lane u_dist2 (.clock(clock), .advance(advance), .vert(in_tri_ff.v2),
                          .point(pt_ff), .normal(nrm_ff), .distance(d2));

   // classify by inside vertices, choose the two crossing edges
   always_comb begin
      in_mask = {~d2[DIST_W-1], ~d1[DIST_W-1], ~d0[DIST_W-1]};
      case_in = CASE_ONE;
      i_sv0   = 2'd0;
      i_sv1   = 2'd1;
      i_a0    = 2'd0;
      i_b0    = 2'd1;
      i_a1    = 2'd0;
      i_b1    = 2'd2;
      unique case (in_mask)
         3'b000: case_in = CASE_NONE;
         3'b111: case_in = CASE_ALL;
         3'b001: begin
            i_sv0 = 2'd0; i_a0 = 2'd0; i_b0 = 2'd1; i_a1 = 2'd0; i_b1 = 2'd2;
         end
         3'b010: begin
            i_sv0 = 2'd1; i_a0 = 2'd1; i_b0 = 2'd0; i_a1 = 2'd1; i_b1 = 2'd2;
         end
         3'b100: begin
            i_sv0 = 2'd2; i_a0 = 2'd2; i_b0 = 2'd0; i_a1 = 2'd2; i_b1 = 2'd1;
         end
         3'b011: begin
            case_in = CASE_TWO;
            i_sv0 = 2'd0; i_sv1 = 2'd1; i_a0 = 2'd0; i_b0 = 2'd2; i_a1 = 2'd1; i_b1 = 2'd2;
         end
         3'b101: begin
            case_in = CASE_TWO;
            i_sv0 = 2'd0; i_sv1 = 2'd2; i_a0 = 2'd0; i_b0 = 2'd1; i_a1 = 2'd2; i_b1 = 2'd1;
         end
         3'b110: begin
            case_in = CASE_TWO;
            i_sv0 = 2'd1; i_sv1 = 2'd2; i_a0 = 2'd1; i_b0 = 2'd0; i_a1 = 2'd2; i_b1 = 2'd0;
         end
      endcase
   end

   always_comb begin
      tri_type t;
      t = dtri_ff[DIST_LAT];
      sel_hold_in.ncase = case_in;
      sel_hold_in.sv0   = pick_vert(i_sv0, t.v0, t.v1, t.v2);
      sel_hold_in.sv1   = pick_vert(i_sv1, t.v0, t.v1, t.v2);
      sel_hold_in.sv2   = t.v2;
      sel_hold_in.color = t.color;
      sel_a_in[0]  = pick_vert(i_a0, t.v0, t.v1, t.v2);
      sel_b_in[0]  = pick_vert(i_b0, t.v0, t.v1, t.v2);
      sel_a_in[1]  = pick_vert(i_a1, t.v0, t.v1, t.v2);
      sel_b_in[1]  = pick_vert(i_b1, t.v0, t.v1, t.v2);
      sel_da_in[0] = pick_dist(i_a0, d0, d1, d2);
      sel_db_in[0] = pick_dist(i_b0, d0, d1, d2);
      sel_da_in[1] = pick_dist(i_a1, d0, d1, d2);
      sel_db_in[1] = pick_dist(i_b1, d0, d1, d2);
   end

   // select stage and delay matched to the crossing lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
         for (int k = 1; k <= LANE_LAT; k++) lval_ff[k] <= 1'b0;
      end else if (advance) begin
         sel_valid_ff <= dval_ff[DIST_LAT];
         lval_ff[1]   <= sel_valid_ff;
         for (int k = 2; k <= LANE_LAT; k++) lval_ff[k] <= lval_ff[k-1];
      end
      if (advance) begin
         sel_hold_ff <= sel_hold_in;
         for (int s = 0; s < 2; s++) begin
            sel_a_ff[s]  <= sel_a_in[s];
            sel_b_ff[s]  <= sel_b_in[s];
            sel_da_ff[s] <= sel_da_in[s];
            sel_db_ff[s] <= sel_db_in[s];
         end
         lhold_ff[1] <= sel_hold_ff;
         for (int k = 2; k <= LANE_LAT; k++) lhold_ff[k] <= lhold_ff[k-1];
      end
   end

   // crossing lanes: an x, y and z lane for each crossing edge
   for (genvar s = 0; s < 2; s++) begin : g_slot
      tpc_isect_lane u_lane_x (.clock(clock), .advance(advance),
         .a_coord(sel_a_ff[s].x), .b_coord(sel_b_ff[s].x),
         .a_dist(sel_da_ff[s]), .b_dist(sel_db_ff[s]), .coord(xs[s].x));
      tpc_isect_lane u_lane_y (.clock(clock), .advance(advance),
         .a_coord(sel_a_ff[s].y), .b_coord(sel_b_ff[s].y),
         .a_dist(sel_da_ff[s]), .b_dist(sel_db_ff[s]), .coord(xs[s].y));
      tpc_isect_lane u_lane_z (.clock(clock), .advance(advance),
         .a_coord(sel_a_ff[s].z), .b_coord(sel_b_ff[s].z),
         .a_dist(sel_da_ff[s]), .b_dist(sel_db_ff[s]), .coord(xs[s].z));
   end

   always_comb begin
      item.ncase = lhold_ff[LANE_LAT].ncase;
      item.sv0   = lhold_ff[LANE_LAT].sv0;
      item.sv1   = lhold_ff[LANE_LAT].sv1;
      item.sv2   = lhold_ff[LANE_LAT].sv2;
      item.color = lhold_ff[LANE_LAT].color;
      item.x0    = xs[0];
      item.x1    = xs[1];
   end

   tpc_out_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .item_valid (lval_ff[LANE_LAT]),
      .item       (item),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### design/tpc_checker.sv
// Port-level checks of the triangle clipper output channel, bound to the top.
// Depends on tpc_pkg and triangle_plane_clipper_unit_macros.svh.
`include "triangle_plane_clipper_unit_macros.svh"
module tpc_checker import tpc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [TRI_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   // a stalled transaction stays offered and unchanged
   `TPC_ASSERT_NEXT(a_stall_valid, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `TPC_ASSERT_NEXT(a_stall_data, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tlast))
   // first half of a split is followed at once by its closing triangle
   `TPC_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tlast)
   // reset empties the output buffer
   `TPC_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid)

endmodule

bind triangle_plane_clipper_unit tpc_checker u_tpc_checker (.*);
